@@ rtl/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants of the BER-TLV header parser
// Parse phases, summary status codes, the result record and the small
// structs passed between the parser and the result queue.
// ----------------------------------------------------------------------------
package btlv_pkg;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_TAGCONT,
      PH_LEN1,
      PH_LENN,
      PH_VALUE,
      PH_ERROR
   } btlv_phase_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_EMPTY        = 3'd1,
      STATUS_TRUNCATED    = 3'd2,
      STATUS_BAD_LENGTH   = 3'd3,
      STATUS_OVERRUN      = 3'd4,
      STATUS_TAG_TOO_LONG = 3'd5
   } btlv_status_type;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [7:0] PAD_BYTE      = 8'h00;
   localparam logic [4:0] LONG_TAG_CODE = 5'h1f;

   localparam int unsigned MAX_LENGTH_BYTES = 4;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic            kind;
      logic [2:0]      class_bits;
      logic [27:0]     tag_number;
      logic [31:0]     value_length;
      logic [15:0]     value_offset;
      logic [15:0]     element_count;
      btlv_status_type status;
      logic            last_result;
   } btlv_result_type;

   // up to two results per input byte, res_a goes out first
   typedef struct packed {
      logic [1:0]      count;
      btlv_result_type res_a;
      btlv_result_type res_b;
   } btlv_push_type;

   typedef struct packed {
      logic                   room;
      logic [QUEUE_LVL_W-1:0] level;
   } btlv_queue_status_type;

   typedef struct packed {
      btlv_phase_type phase;
      logic           count_zero;
   } btlv_parse_status_type;

endpackage

@@ rtl/btlv_if.sv @@
// ----------------------------------------------------------------------------
// btlv channel interfaces
// Valid/ready channels for input bytes, results and the mode register.
// ----------------------------------------------------------------------------
interface btlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface btlv_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  class_bits;
   logic [27:0] tag_number;
   logic [31:0] value_length;
   logic [15:0] value_offset;
   logic [15:0] element_count;
   logic [2:0]  status;
   logic        last_result;

   modport source (output valid, output kind, output class_bits, output tag_number,
                   output value_length, output value_offset, output element_count,
                   output status, output last_result, input ready);
   modport sink   (input valid, input kind, input class_bits, input tag_number,
                   input value_length, input value_offset, input element_count,
                   input status, input last_result, output ready);
endinterface

interface btlv_csr_if;
   logic valid;
   logic ready;
   logic values_present;

   modport source (output valid, output values_present, input ready);
   modport sink   (input valid, input values_present, output ready);
endinterface

@@ rtl/ber_tlv_header_parser.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_header_parser: streaming BER/DER tag-length header parser
//
// req_chan carries one buffer byte per transfer, with end_of_buffer on the
// final byte. Padding 0x00 bytes before a tag are skipped; each completed
// header (tag and length) gives one result on rsp_chan, and the final byte
// of a buffer adds a summary result with the element count and a status.
// csr_chan writes values_present (1 = value bytes follow each header,
// 0 = tag-length list); write it only while the block is idle.
// A result enters the queue as its byte is accepted and is offered on
// rsp_chan from the queue's registered head. One byte per cycle is taken
// while req_chan.ready is high; the parse state is registered per byte.
// Results wait in a four-entry queue; req_chan.ready is low while more than
// two are queued, so a stalled receiver holds off the input and none is lost.
// Reset: values_present returns to 1, the parser waits for a tag at buffer
// offset zero and the queue is empty.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser #(
   parameter longint unsigned MAX_BUFFER_BYTES   = 65536,
   parameter int unsigned     MAX_TAG_CONT_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   btlv_req_if.sink   req_chan,
   btlv_rsp_if.source rsp_chan,
   btlv_csr_if.sink   csr_chan
);
   import btlv_pkg::*;

   btlv_push_type         push;
   btlv_queue_status_type queue_status;
   btlv_parse_status_type parse_status;

   btlv_parser #(
      .MAX_BUFFER_BYTES   (MAX_BUFFER_BYTES),
      .MAX_TAG_CONT_BYTES (MAX_TAG_CONT_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .csr          (csr_chan),
      .queue_status (queue_status),
      .push         (push),
      .parse_status (parse_status)
   );

   btlv_result_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .rsp          (rsp_chan),
      .queue_status (queue_status)
   );

   // queue never holds more results than it has slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // no byte is taken unless both results it may cause fit
   a_room_before_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |->
         (queue_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2)))
      else $error("byte accepted without queue room");

   // a summary always closes the results of its byte
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_SUMMARY)) |-> rsp_chan.last_result)
      else $error("summary result without last_result");

   // the byte that ends a buffer leaves a fresh parse behind
   a_buffer_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.end_of_buffer) |=>
         ((parse_status.phase == PH_SKIP) && parse_status.count_zero))
      else $error("parse state not cleared after end of buffer");

endmodule

@@ rtl/btlv_parser.sv @@
// ----------------------------------------------------------------------------
// btlv_parser: per-byte header parse state
// Updates the parse state for each accepted byte and builds the header and
// end-of-buffer results that the byte causes.
// ----------------------------------------------------------------------------
module btlv_parser #(
   parameter longint unsigned MAX_BUFFER_BYTES   = 65536,
   parameter int unsigned     MAX_TAG_CONT_BYTES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   btlv_req_if.sink                       req,
   btlv_csr_if.sink                       csr,
   input  btlv_pkg::btlv_queue_status_type queue_status,
   output btlv_pkg::btlv_push_type        push,
   output btlv_pkg::btlv_parse_status_type parse_status
);
   import btlv_pkg::*;

   localparam int unsigned POS_W  = $clog2(MAX_BUFFER_BYTES);
   localparam int unsigned SEEN_W = $clog2(MAX_TAG_CONT_BYTES + 2);
   localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(MAX_BUFFER_BYTES - 1);
   localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(MAX_TAG_CONT_BYTES);

   logic                values_present_ff;
   btlv_phase_type      phase_ff, phase_in;
   logic [27:0]         tag_acc_ff, tag_acc_in;
   logic [SEEN_W-1:0]   tag_seen_ff, tag_seen_in;
   logic [2:0]          class_ff, class_in;
   logic [31:0]         len_acc_ff, len_acc_in;
   logic [2:0]          len_left_ff, len_left_in;
   logic [31:0]         value_left_ff, value_left_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [15:0]         count_ff, count_in;
   btlv_status_type     error_ff, error_in;

   logic                accept;
   logic                hdr;
   logic [POS_W-1:0]    next_pos;
   logic [15:0]         count_sat;
   logic [SEEN_W-1:0]   seen_inc;
   btlv_status_type     sum_status;
   btlv_result_type     hdr_res, sum_res;

   assign req.ready = queue_status.room;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign parse_status.phase      = phase_ff;
   assign parse_status.count_zero = (count_ff == 16'd0);

   always_comb begin
      phase_in      = phase_ff;
      tag_acc_in    = tag_acc_ff;
      tag_seen_in   = tag_seen_ff;
      class_in      = class_ff;
      len_acc_in    = len_acc_ff;
      len_left_in   = len_left_ff;
      value_left_in = value_left_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      error_in      = error_ff;
      hdr           = 1'b0;
      sum_status    = STATUS_OK;
      hdr_res       = '0;
      sum_res       = '0;
      push          = '0;

      next_pos  = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      count_sat = (count_ff == 16'hffff) ? count_ff : count_ff + 16'd1;
      seen_inc  = tag_seen_ff + 1'b1;

      if (accept) begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (req.data_byte != PAD_BYTE) begin
                  class_in = req.data_byte[7:5];
                  if (req.data_byte[4:0] == LONG_TAG_CODE) begin
                     tag_acc_in  = '0;
                     tag_seen_in = '0;
                     phase_in    = PH_TAGCONT;
                  end else begin
                     tag_acc_in = 28'(req.data_byte[4:0]);
                     phase_in   = PH_LEN1;
                  end
               end
            end
            PH_TAGCONT: begin
               tag_seen_in = seen_inc;
               if (seen_inc > SEEN_LIMIT) begin
                  error_in = STATUS_TAG_TOO_LONG;
                  phase_in = PH_ERROR;
               end else begin
                  tag_acc_in = {tag_acc_ff[20:0], req.data_byte[6:0]};
                  if (!req.data_byte[7]) begin
                     phase_in = PH_LEN1;
                  end
               end
            end
            PH_LEN1: begin
               if (req.data_byte[7]) begin
                  if ((req.data_byte[6:0] == 7'd0) ||
                      (req.data_byte[6:0] > 7'(MAX_LENGTH_BYTES))) begin
                     error_in = STATUS_BAD_LENGTH;
                     phase_in = PH_ERROR;
                  end else begin
                     len_acc_in  = '0;
                     len_left_in = req.data_byte[2:0];
                     phase_in    = PH_LENN;
                  end
               end else begin
                  len_acc_in = 32'(req.data_byte);
                  hdr        = 1'b1;
               end
            end
            PH_LENN: begin
               len_acc_in  = {len_acc_ff[23:0], req.data_byte};
               len_left_in = len_left_ff - 3'd1;
               if (len_left_ff == 3'd1) begin
                  hdr = 1'b1;
               end
            end
            PH_VALUE: begin
               value_left_in = value_left_ff - 32'd1;
               if (value_left_ff == 32'd1) begin
                  phase_in = PH_SKIP;
               end
            end
            default: begin
            end
         endcase

         if (hdr) begin
            count_in = count_sat;
            if (values_present_ff && (len_acc_in != 32'd0)) begin
               value_left_in = len_acc_in;
               phase_in      = PH_VALUE;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         pos_in = next_pos;

         priority if (error_in != STATUS_OK) begin
            sum_status = error_in;
         end else if ((phase_in == PH_TAGCONT) || (phase_in == PH_LEN1) ||
                      (phase_in == PH_LENN)) begin
            sum_status = STATUS_TRUNCATED;
         end else if ((phase_in == PH_VALUE) && (value_left_in != 32'd0)) begin
            sum_status = STATUS_OVERRUN;
         end else if (count_in == 16'd0) begin
            sum_status = STATUS_EMPTY;
         end else begin
            sum_status = STATUS_OK;
         end

         hdr_res.kind          = KIND_HEADER;
         hdr_res.class_bits    = class_in;
         hdr_res.tag_number    = tag_acc_in;
         hdr_res.value_length  = len_acc_in;
         hdr_res.value_offset  = 16'(next_pos);
         hdr_res.element_count = count_in;
         hdr_res.status        = STATUS_OK;
         hdr_res.last_result   = !req.end_of_buffer;

         sum_res.kind          = KIND_SUMMARY;
         sum_res.value_offset  = 16'(next_pos);
         sum_res.element_count = count_in;
         sum_res.status        = sum_status;
         sum_res.last_result   = 1'b1;

         if (hdr && req.end_of_buffer) begin
            push.count = 2'd2;
            push.res_a = hdr_res;
            push.res_b = sum_res;
         end else if (hdr) begin
            push.count = 2'd1;
            push.res_a = hdr_res;
         end else if (req.end_of_buffer) begin
            push.count = 2'd1;
            push.res_a = sum_res;
         end

         // buffer done: back to a fresh parse
         if (req.end_of_buffer) begin
            phase_in      = PH_SKIP;
            tag_acc_in    = '0;
            tag_seen_in   = '0;
            class_in      = '0;
            len_acc_in    = '0;
            len_left_in   = '0;
            value_left_in = '0;
            pos_in        = '0;
            count_in      = '0;
            error_in      = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         values_present_ff <= 1'b1;
         phase_ff          <= PH_SKIP;
         tag_acc_ff        <= '0;
         tag_seen_ff       <= '0;
         class_ff          <= '0;
         len_acc_ff        <= '0;
         len_left_ff       <= '0;
         value_left_ff     <= '0;
         pos_ff            <= '0;
         count_ff          <= '0;
         error_ff          <= STATUS_OK;
      end else begin
         if (csr.valid) begin
            values_present_ff <= csr.values_present;
         end
         phase_ff      <= phase_in;
         tag_acc_ff    <= tag_acc_in;
         tag_seen_ff   <= tag_seen_in;
         class_ff      <= class_in;
         len_acc_ff    <= len_acc_in;
         len_left_ff   <= len_left_in;
         value_left_ff <= value_left_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         error_ff      <= error_in;
      end
   end

endmodule

@@ rtl/btlv_result_queue.sv @@
// ----------------------------------------------------------------------------
// btlv_result_queue: result buffer in front of the response channel
// Takes up to two results per cycle from the parser and hands them out one
// transfer at a time.
// ----------------------------------------------------------------------------
module btlv_result_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  btlv_pkg::btlv_push_type         push,
   btlv_rsp_if.source                      rsp,
   output btlv_pkg::btlv_queue_status_type queue_status
);
   import btlv_pkg::*;

   btlv_result_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_next;
   logic [QUEUE_LVL_W-1:0]  level_ff, level_in;
   logic                    pop;
   btlv_result_type         head;

   assign pop         = rsp.valid && rsp.ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign head        = slot_ff[rd_ptr_ff];

   assign rsp.valid         = (level_ff != '0);
   assign rsp.kind          = head.kind;
   assign rsp.class_bits    = head.class_bits;
   assign rsp.tag_number    = head.tag_number;
   assign rsp.value_length  = head.value_length;
   assign rsp.value_offset  = head.value_offset;
   assign rsp.element_count = head.element_count;
   assign rsp.status        = head.status;
   assign rsp.last_result   = head.last_result;

   // room for two more results, decided from the registered level only
   assign queue_status.room  = (level_ff <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
   assign queue_status.level = level_ff;

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      level_in  = level_ff + QUEUE_LVL_W'(push.count) - QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.res_a;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_next] <= push.res_b;
      end
   end

endmodule

@@ verif/ber_tlv_header_parser_tb.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_tb: self-checking bench for the BER-TLV header parser
// Feeds encoded buffers byte by byte under both values_present settings and
// checks every header and end-of-buffer summary against an in-bench parser
// model. A short table of hand-picked buffers comes first, then random
// buffers: mostly well-formed, some truncated, malformed or noisy. One long
// buffer runs with no idling on either side.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_tb;
   import btlv_pkg::*;

   localparam int RESET_CYCLES      = 12;
   localparam int IDLE_PERCENT      = 8;
   localparam int TAIL_CYCLES       = 8;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int TAG_CONT_LIMIT    = 4;
   localparam int LONG_FRAME_HEADERS = 50;
   localparam int DIRECTED_ROWS     = 25;

   typedef enum int {
      FAULT_BAD_LENGTH,
      FAULT_LONG_TAG,
      FAULT_NOISE,
      FAULT_TRUNCATE
   } fault_type;

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            eob;
      logic            typed;
      btlv_status_type status;
      logic [15:0]     count;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   btlv_req_if req_chan ();
   btlv_rsp_if rsp_chan ();
   btlv_csr_if csr_chan ();

   ber_tlv_header_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // typed expectations travel with the byte so the monitor sees them at the transfer
   logic            row_typed;
   btlv_status_type row_status;
   logic [15:0]     row_count;

   logic quiet       = 1'b0;
   int   hold_asked  = 0;

   // parser model state
   btlv_phase_type  parse_phase    = PH_SKIP;
   logic [27:0]     tag_acc        = '0;
   int              tag_cont_seen  = 0;
   logic [2:0]      tag_class      = '0;
   logic [31:0]     len_acc        = '0;
   int              len_bytes_left = 0;
   logic [31:0]     value_left     = '0;
   logic [15:0]     byte_pos       = '0;
   logic [15:0]     header_count   = '0;
   btlv_status_type first_error    = STATUS_OK;
   logic            values_mode    = 1'b1;

   btlv_result_type expected_results[$];
   logic [7:0]      frame_bytes[$];
   directed_row_type directed_rows [DIRECTED_ROWS];

   int mismatch_count   = 0;
   int results_checked  = 0;
   int summaries_seen   = 0;
   int bytes_sent       = 0;
   int stalled_cycles   = 0;
   int status_seen [8];

   function automatic void predict_results(input logic [7:0] b, input logic eob,
                                           input logic typed, input btlv_status_type typed_st,
                                           input logic [15:0] typed_cnt);
      btlv_result_type hdr_res;
      btlv_result_type sum_res;
      logic [15:0]     next_pos;
      logic            has_hdr;
      next_pos = byte_pos + 16'd1;
      has_hdr  = 1'b0;
      hdr_res  = '0;
      sum_res  = '0;
      case (parse_phase)
         PH_SKIP: begin
            if (b != PAD_BYTE) begin
               tag_class = b[7:5];
               if (b[4:0] == LONG_TAG_CODE) begin
                  tag_acc       = '0;
                  tag_cont_seen = 0;
                  parse_phase   = PH_TAGCONT;
               end else begin
                  tag_acc     = 28'(b[4:0]);
                  parse_phase = PH_LEN1;
               end
            end
         end
         PH_TAGCONT: begin
            tag_cont_seen++;
            if (tag_cont_seen > TAG_CONT_LIMIT) begin
               first_error = STATUS_TAG_TOO_LONG;
               parse_phase = PH_ERROR;
            end else begin
               tag_acc = {tag_acc[20:0], b[6:0]};
               if (!b[7]) parse_phase = PH_LEN1;
            end
         end
         PH_LEN1: begin
            if (b[7]) begin
               if (b[6:0] == 7'd0 || b[6:0] > MAX_LENGTH_BYTES) begin
                  first_error = STATUS_BAD_LENGTH;
                  parse_phase = PH_ERROR;
               end else begin
                  len_acc        = '0;
                  len_bytes_left = int'(b[6:0]);
                  parse_phase    = PH_LENN;
               end
            end else begin
               len_acc = 32'(b);
               has_hdr = 1'b1;
            end
         end
         PH_LENN: begin
            len_acc = {len_acc[23:0], b};
            len_bytes_left--;
            if (len_bytes_left == 0) has_hdr = 1'b1;
         end
         PH_VALUE: begin
            value_left--;
            if (value_left == 0) parse_phase = PH_SKIP;
         end
         default: ;
      endcase

      if (has_hdr) begin
         if (header_count != 16'hffff) header_count++;
         hdr_res.kind          = KIND_HEADER;
         hdr_res.class_bits    = tag_class;
         hdr_res.tag_number    = tag_acc;
         hdr_res.value_length  = len_acc;
         hdr_res.value_offset  = next_pos;
         hdr_res.element_count = header_count;
         hdr_res.status        = STATUS_OK;
         if (values_mode && len_acc != 0) begin
            value_left  = len_acc;
            parse_phase = PH_VALUE;
         end else begin
            parse_phase = PH_SKIP;
         end
      end
      byte_pos = next_pos;

      if (eob) begin
         sum_res.kind          = KIND_SUMMARY;
         sum_res.value_offset  = byte_pos;
         sum_res.element_count = header_count;
         if (first_error != STATUS_OK)
            sum_res.status = first_error;
         else if (parse_phase == PH_TAGCONT || parse_phase == PH_LEN1 || parse_phase == PH_LENN)
            sum_res.status = STATUS_TRUNCATED;
         else if (parse_phase == PH_VALUE && value_left != 0)
            sum_res.status = STATUS_OVERRUN;
         else if (header_count == 0)
            sum_res.status = STATUS_EMPTY;
         else
            sum_res.status = STATUS_OK;
         if (typed) begin
            sum_res.status        = typed_st;
            sum_res.element_count = typed_cnt;
         end
         sum_res.last_result = 1'b1;
         parse_phase    = PH_SKIP;
         tag_acc        = '0;
         tag_cont_seen  = 0;
         tag_class      = '0;
         len_acc        = '0;
         len_bytes_left = 0;
         value_left     = '0;
         byte_pos       = '0;
         header_count   = '0;
         first_error    = STATUS_OK;
      end else begin
         hdr_res.last_result = has_hdr;
      end

      if (has_hdr) expected_results.push_back(hdr_res);
      if (eob) expected_results.push_back(sum_res);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("error: %s", msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_checked, name, got, want));
   endtask

   task automatic check_result();
      btlv_result_type want;
      results_checked++;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0b)",
                                   results_checked, rsp_chan.kind));
      end else begin
         want = expected_results.pop_front();
         compare_field("kind", 32'(rsp_chan.kind), 32'(want.kind));
         compare_field("class_bits", 32'(rsp_chan.class_bits), 32'(want.class_bits));
         compare_field("tag_number", 32'(rsp_chan.tag_number), 32'(want.tag_number));
         compare_field("value_length", rsp_chan.value_length, want.value_length);
         compare_field("value_offset", 32'(rsp_chan.value_offset), 32'(want.value_offset));
         compare_field("element_count", 32'(rsp_chan.element_count),
                       32'(want.element_count));
         compare_field("status", 32'(rsp_chan.status), 32'(want.status));
         compare_field("last_result", 32'(rsp_chan.last_result), 32'(want.last_result));
         if (want.kind == KIND_SUMMARY) begin
            summaries_seen++;
            status_seen[want.status]++;
         end
      end
   endtask

   // monitor: model update on input transfers, checks on result transfers, watchdog
   always @(posedge clock) begin
      logic req_fire;
      logic rsp_fire;
      logic csr_fire;
      req_fire = !reset && req_chan.valid && req_chan.ready;
      rsp_fire = !reset && rsp_chan.valid && rsp_chan.ready;
      csr_fire = !reset && csr_chan.valid && csr_chan.ready;
      if (csr_fire) values_mode = csr_chan.values_present;
      if (req_fire)
         predict_results(req_chan.data_byte, req_chan.end_of_buffer,
                         row_typed, row_status, row_count);
      if (rsp_fire) check_result();
      if (req_fire || rsp_fire || csr_fire)
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  stalled_cycles, expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // result receiver: random back-pressure plus one long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   function automatic void append_element();
      int          pads;
      int          ntag;
      int          nlen;
      logic [7:0]  lead_byte;
      logic [31:0] len;
      pads = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (pads) frame_bytes.push_back(PAD_BYTE);
      if ($urandom_range(9) < 3) begin
         ntag = $urandom_range(1, TAG_CONT_LIMIT);
         frame_bytes.push_back({3'($urandom), LONG_TAG_CODE});
         for (int i = 1; i <= ntag; i++) frame_bytes.push_back({(i < ntag), 7'($urandom)});
      end else begin
         lead_byte = 8'($urandom);
         if (lead_byte[4:0] == LONG_TAG_CODE) lead_byte[4:0] = 5'h1e;
         if (lead_byte == PAD_BYTE) lead_byte = 8'h01;
         frame_bytes.push_back(lead_byte);
      end
      nlen = ($urandom_range(2) == 0) ? $urandom_range(1, MAX_LENGTH_BYTES) : 0;
      if (values_mode)
         len = ($urandom_range(7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      else if (nlen == 0)
         len = $urandom_range(0, 127);
      else
         len = $urandom >> (8 * (4 - nlen));
      if (nlen == 0) begin
         frame_bytes.push_back(len[7:0]);
      end else begin
         frame_bytes.push_back(8'h80 | 8'(nlen));
         for (int k = nlen - 1; k >= 0; k--) frame_bytes.push_back(len[8*k +: 8]);
      end
      if (values_mode) repeat (len) frame_bytes.push_back(8'($urandom));
   endfunction

   function automatic void append_fault(input fault_type fault);
      int n;
      case (fault)
         FAULT_BAD_LENGTH: begin
            frame_bytes.push_back({3'($urandom), 5'($urandom_range(1, 30))});
            frame_bytes.push_back(($urandom_range(1) == 0) ? 8'h80
                                                           : 8'($urandom_range(8'h85, 8'hff)));
         end
         FAULT_LONG_TAG: begin
            frame_bytes.push_back({3'($urandom), LONG_TAG_CODE});
            n = $urandom_range(TAG_CONT_LIMIT + 1, TAG_CONT_LIMIT + 3);
            repeat (n) frame_bytes.push_back({1'b1, 7'($urandom)});
         end
         default: begin
            n = $urandom_range(1, 8);
            repeat (n) frame_bytes.push_back(8'($urandom));
         end
      endcase
   endfunction

   // mostly well-formed buffers, a fifth broken, a few of padding only
   function automatic void build_frame();
      int        roll;
      int        n;
      int        cut;
      fault_type fault;
      frame_bytes.delete();
      roll = $urandom_range(99);
      if (roll < 5) begin
         n = $urandom_range(1, 3);
         repeat (n) frame_bytes.push_back(PAD_BYTE);
      end else begin
         n = $urandom_range(1, 5);
         repeat (n) append_element();
         if (roll >= 80) begin
            fault = fault_type'($urandom_range(3));
            if (fault == FAULT_TRUNCATE) begin
               cut = $urandom_range(1, 3);
               while (cut > 0 && frame_bytes.size() > 1) begin
                  void'(frame_bytes.pop_back());
                  cut--;
               end
            end else begin
               append_fault(fault);
               if ($urandom_range(1) == 0) append_element();
            end
         end else if ($urandom_range(4) == 0) begin
            frame_bytes.push_back(PAD_BYTE);
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eob, input logic typed,
                            input btlv_status_type st, input logic [15:0] cnt);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b;
      req_chan.end_of_buffer <= eob;
      row_typed              <= typed;
      row_status             <= st;
      row_count              <= cnt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_values_present(input logic mode);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_chan.valid          <= 1'b1;
      csr_chan.values_present <= mode;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_frames(input int byte_budget, input logic with_hold_off);
      int start;
      int size;
      logic asked;
      start = bytes_sent;
      asked = 1'b0;
      while (bytes_sent - start < byte_budget) begin
         if (with_hold_off && !asked && bytes_sent - start >= byte_budget / 2) begin
            // receiver stalls while bytes keep coming, so the result queue fills
            hold_asked <= hold_asked + 1;
            asked = 1'b1;
         end
         build_frame();
         size = frame_bytes.size();
         for (int i = 0; i < size; i++)
            send_byte(frame_bytes[i], i == size - 1, 1'b0, STATUS_OK, 16'd0);
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.data_byte      <= 8'h00;
      req_chan.end_of_buffer  <= 1'b0;
      csr_chan.valid          <= 1'b0;
      csr_chan.values_present <= 1'b1;
      row_typed               <= 1'b0;
      row_status              <= STATUS_OK;
      row_count               <= 16'd0;
      for (int s = 0; s < 8; s++) status_seen[s] = 0;
      directed_rows = '{
         // padding only
         '{8'h00, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h00, 1'b1, 1'b1, STATUS_EMPTY,        16'd0},
         // class 7 short tag with one value byte, then a long tag with a
         // four-byte all-ones length that the buffer cannot deliver
         '{8'h00, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hfe, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h01, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h1f, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h7f, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h84, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b1, 1'b1, STATUS_OVERRUN,      16'd2},
         // indefinite length form
         '{8'h01, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h80, 1'b1, 1'b1, STATUS_BAD_LENGTH,   16'd0},
         // more length bytes than supported
         '{8'h01, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h85, 1'b1, 1'b1, STATUS_BAD_LENGTH,   16'd0},
         // five continuation bytes
         '{8'h3f, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'hff, 1'b0, 1'b0, STATUS_OK,           16'd0},
         '{8'h80, 1'b1, 1'b1, STATUS_TAG_TOO_LONG, 16'd0},
         // buffer ends inside a tag
         '{8'h1f, 1'b1, 1'b1, STATUS_TRUNCATED,    16'd0}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // register still at its reset value
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(directed_rows[i].data_byte, directed_rows[i].eob, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].count);

      write_values_present(1'b0);
      run_random_frames(200, 1'b1);
      write_values_present(1'b1);
      run_random_frames(200, 1'b0);

      // one long buffer with no idling on either side
      quiet <= 1'b1;
      write_values_present(1'b0);
      for (int i = 0; i < LONG_FRAME_HEADERS; i++) begin
         send_byte({3'($urandom), 5'($urandom_range(1, 30))}, 1'b0, 1'b0, STATUS_OK, 16'd0);
         send_byte({1'b0, 7'($urandom)}, i == LONG_FRAME_HEADERS - 1,
                   1'b0, STATUS_OK, 16'd0);
      end
      quiet <= 1'b0;

      write_values_present(1'b1);
      run_random_frames(180, 1'b0);
      write_values_present(1'b0);
      run_random_frames(180, 1'b0);

      req_chan.valid <= 1'b0;
      wait_drained();
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("run covered %0d bytes in %0d buffers under both value modes, %0d results checked",
               bytes_sent, summaries_seen, results_checked);
      $display("buffer status ok/empty/truncated/bad length/overrun/tag too long: %s",
               $sformatf("%0d/%0d/%0d/%0d/%0d/%0d",
                         status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
                         status_seen[STATUS_TRUNCATED], status_seen[STATUS_BAD_LENGTH],
                         status_seen[STATUS_OVERRUN], status_seen[STATUS_TAG_TOO_LONG]));
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/btlv_pkg.sv
rtl/btlv_if.sv
rtl/btlv_parser.sv
rtl/btlv_result_queue.sv
rtl/ber_tlv_header_parser.sv
verif/ber_tlv_header_parser_tb.sv
